/* hw/rtl/sfs_pkg.sv */
// sfs_pkg: shared types and constants of the solenoid fire scheduler
// used by the top level, the front decoder, the command fifo and the back engine
package sfs_pkg;

    // request function codes as they arrive on the input channel
    localparam logic [3:0] FUNC_PUSH_BACK  = 4'd0;
    localparam logic [3:0] FUNC_PUSH_FRONT = 4'd1;
    localparam logic [3:0] FUNC_SCHEDULE   = 4'd2;
    localparam logic [3:0] FUNC_TIME       = 4'd3;
    localparam logic [3:0] FUNC_SET_BITS   = 4'd4;
    localparam logic [3:0] FUNC_FIRE       = 4'd5;
    localparam logic [3:0] FUNC_TICK       = 4'd6;
    localparam logic [3:0] FUNC_ENABLE     = 4'd7;
    localparam logic [3:0] FUNC_DISABLE    = 4'd8;
    localparam logic [3:0] FUNC_CLEAR      = 4'd9;

    // port constants
    localparam logic [7:0] NIBBLE_HIGH     = 8'hF0;
    localparam logic [3:0] NONE_CODE       = 4'hF;
    localparam logic [7:0] PORT_RESET      = 8'hFF;

    typedef enum logic [3:0] {
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_SCHEDULE,
        OP_TIME,
        OP_SET_BITS,
        OP_FIRE,
        OP_TICK,
        OP_ENABLE,
        OP_DISABLE,
        OP_CLEAR,
        OP_NONE
    } sfs_op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUSH_BACK,
        ST_PUSH_FRONT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_TICK
    } sfs_state_t;

    // decoded request handed from front to back
    typedef struct packed {
        sfs_op_t     op;
        logic [3:0]  solenoid;
        logic [7:0]  repeat_count;
        logic        override_enable;
        logic [31:0] event_time;
        logic        level;
        logic [7:0]  bit_mask;
        logic [7:0]  hold_ticks;
    } sfs_cmd_t;

    // one timed slot, in-use bit kept apart in flip-flops
    typedef struct packed {
        logic [31:0] when;
        logic        ovr;
        logic [3:0]  sol;
        logic [7:0]  reps;
    } sfs_slot_t;

    typedef struct packed {
        logic [7:0] port_byte;
        logic       port_written;
        logic       accepted;
        logic [6:0] queue_level;
    } sfs_result_t;

endpackage

/* hw/rtl/sfs_in_if.sv */
// sfs_in_if: request channel of the solenoid fire scheduler
// valid/ready handshake with the request fields; no dependencies
interface sfs_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  func;
    logic [3:0]  solenoid;
    logic [7:0]  repeat_count;
    logic        override_enable;
    logic [31:0] event_time;
    logic        level;
    logic [7:0]  bit_mask;
    logic [7:0]  hold_ticks;

    modport source (
        output valid, func, solenoid, repeat_count, override_enable,
               event_time, level, bit_mask, hold_ticks,
        input  ready
    );
    modport sink (
        input  valid, func, solenoid, repeat_count, override_enable,
               event_time, level, bit_mask, hold_ticks,
        output ready
    );
endinterface

/* hw/rtl/sfs_out_if.sv */
// sfs_out_if: result channel of the solenoid fire scheduler
// valid/ready handshake with the result fields; no dependencies
interface sfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] port_byte;
    logic       port_written;
    logic       accepted;
    logic [6:0] queue_level;

    modport source (
        output valid, port_byte, port_written, accepted, queue_level,
        input  ready
    );
    modport sink (
        input  valid, port_byte, port_written, accepted, queue_level,
        output ready
    );
endinterface

/* hw/rtl/solenoid_fire_scheduler.sv */
// solenoid_fire_scheduler: top level of the solenoid port driver
// depends on sfs_pkg, sfs_in_if, sfs_out_if, sfs_front, sfs_cmd_fifo and sfs_back
//
// usage:
//   cmd carries one request per valid/ready handshake (push, schedule, time,
//   set bits, fire, tick, enable, disable, clear); result returns exactly one
//   result per request, in order, with the port byte and queue level after it.
//   cfg_write/cfg_data load the default port byte register; reset returns it
//   to ff, and the init state after reset copies it into the port.
// request flow:
//   a request passes a two-entry queue of registers before the engine takes it.
//   most requests finish in the idle state; a tick that pulls from the queue reads
//   the head entry in idle and updates the port in the tick state; a dropped push
//   finishes in idle, any other push writes one queue entry per repeat (fewer when
//   the queue fills), a time update reads and checks each timed slot in turn and
//   moves due slots into the queue. the engine runs one request at a time,
//   taking a new one only in idle; its result is registered when it finishes.
// reset: queue and timed slots empty, port at the default byte, timer idle,
//   queue enabled. a stalled result holds in the output register; the engine
//   then waits while the front keeps taking up to two more requests.
module solenoid_fire_scheduler #(
    parameter int QUEUE_DEPTH   = 64,
    parameter int TIMED_SLOTS   = 32,
    parameter int NUM_MOMENTARY = 15
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    sfs_in_if.sink     cmd,
    sfs_out_if.source  result
);

    logic              f_valid, f_ready;
    sfs_pkg::sfs_cmd_t f_cmd;
    logic              b_valid, b_pop;
    sfs_pkg::sfs_cmd_t b_cmd;

    // request decode
    sfs_front u_front (
        .cmd        (cmd),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd)
    );

    // decoupling queue
    sfs_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (b_valid),
        .pop        (b_pop),
        .pop_cmd    (b_cmd)
    );

    // execution engine
    sfs_back #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TIMED_SLOTS   (TIMED_SLOTS),
        .NUM_MOMENTARY (NUM_MOMENTARY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd_valid (b_valid),
        .cmd_pop   (b_pop),
        .cmd       (b_cmd),
        .result    (result)
    );

endmodule

/* hw/rtl/sfs_front.sv */
// sfs_front: takes requests from the input channel and decodes the function code
// depends on sfs_pkg and sfs_in_if
module sfs_front (
    sfs_in_if.sink          cmd,
    output logic            push_valid,
    input  logic            push_ready,
    output sfs_pkg::sfs_cmd_t push_cmd
);

    sfs_pkg::sfs_op_t op;

    // function code to operation, unused codes do nothing
    always_comb
    begin
        case (cmd.func)
            sfs_pkg::FUNC_PUSH_BACK:  op = sfs_pkg::OP_PUSH_BACK;
            sfs_pkg::FUNC_PUSH_FRONT: op = sfs_pkg::OP_PUSH_FRONT;
            sfs_pkg::FUNC_SCHEDULE:   op = sfs_pkg::OP_SCHEDULE;
            sfs_pkg::FUNC_TIME:       op = sfs_pkg::OP_TIME;
            sfs_pkg::FUNC_SET_BITS:   op = sfs_pkg::OP_SET_BITS;
            sfs_pkg::FUNC_FIRE:       op = sfs_pkg::OP_FIRE;
            sfs_pkg::FUNC_TICK:       op = sfs_pkg::OP_TICK;
            sfs_pkg::FUNC_ENABLE:     op = sfs_pkg::OP_ENABLE;
            sfs_pkg::FUNC_DISABLE:    op = sfs_pkg::OP_DISABLE;
            sfs_pkg::FUNC_CLEAR:      op = sfs_pkg::OP_CLEAR;
            default:                  op = sfs_pkg::OP_NONE;
        endcase
    end

    // handshake straight into the command fifo
    assign cmd.ready  = push_ready;
    assign push_valid = cmd.valid;

    always_comb
    begin
        push_cmd.op              = op;
        push_cmd.solenoid        = cmd.solenoid;
        push_cmd.repeat_count    = cmd.repeat_count;
        push_cmd.override_enable = cmd.override_enable;
        push_cmd.event_time      = cmd.event_time;
        push_cmd.level           = cmd.level;
        push_cmd.bit_mask        = cmd.bit_mask;
        push_cmd.hold_ticks      = cmd.hold_ticks;
    end

endmodule

/* hw/rtl/sfs_cmd_fifo.sv */
// sfs_cmd_fifo: two-entry queue of decoded requests between front and back
// depends on sfs_pkg
module sfs_cmd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  sfs_pkg::sfs_cmd_t push_cmd,
    output logic              pop_valid,
    input  logic              pop,
    output sfs_pkg::sfs_cmd_t pop_cmd
);

    sfs_pkg::sfs_cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hw/rtl/sfs_back.sv */
// sfs_back: executes decoded requests: fire queue, timed slots, port and restore timer
// depends on sfs_pkg and sfs_out_if
module sfs_back #(
    parameter int QUEUE_DEPTH   = 64,
    parameter int TIMED_SLOTS   = 32,
    parameter int NUM_MOMENTARY = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  sfs_pkg::sfs_cmd_t cmd,
    sfs_out_if.source         result
);

    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = (TIMED_SLOTS > 1) ? $clog2(TIMED_SLOTS) : 1;

    // memories
    logic [3:0]         queue_mem [QUEUE_DEPTH];
    sfs_pkg::sfs_slot_t slot_mem  [TIMED_SLOTS];

    // registers
    sfs_pkg::sfs_state_t  state_reg, state_next;
    logic [7:0]           default_reg;
    logic [7:0]           port_reg, port_next;
    logic [7:0]           restore_mask_reg, restore_mask_next;
    logic [7:0]           countdown_reg, countdown_next;
    logic                 enabled_reg, enabled_next;
    logic [QA-1:0]        head_reg, head_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [TIMED_SLOTS-1:0] used_reg, used_next;
    logic [31:0]          time_reg, time_next;
    logic [7:0]           rep_reg, rep_next;
    logic [3:0]           psol_reg, psol_next;
    logic                 in_scan_reg, in_scan_next;
    logic [SW-1:0]        scan_idx_reg, scan_idx_next;
    logic                 out_valid_reg, out_valid_next;
    sfs_pkg::sfs_result_t out_reg, out_next;
    logic [3:0]           q_rd_data_reg;
    sfs_pkg::sfs_slot_t   slot_rd_data_reg;

    // combinational helpers
    logic          out_free, start;
    logic          q_full, rep_done;
    logic [FW:0]   tail_sum;
    logic [QA-1:0] tail_addr, head_dec, head_inc;
    logic          free_found;
    logic [SW-1:0] free_idx;
    logic          push_ok, front_ok, due, scan_push_ok, scan_last;
    logic          emit, written, accepted;
    logic          q_wr_en, q_rd_en, slot_wr_en, slot_rd_en;
    logic [QA-1:0] q_wr_addr;
    logic [7:0]    tick_cd;
    logic [7:0]    tick_mask;
    logic [7:0]    tick_port;

    assign out_free = !out_valid_reg || result.ready;
    assign start    = (state_reg == sfs_pkg::ST_IDLE) && cmd_valid && out_free;
    assign cmd_pop  = start;

    // queue address arithmetic with wrap at any depth
    assign q_full    = (fill_reg == FW'(QUEUE_DEPTH));
    assign rep_done  = (rep_reg == 8'd0) || q_full;
    assign tail_sum  = (FW+1)'(head_reg) + (FW+1)'(fill_reg);
    assign tail_addr = (tail_sum >= (FW+1)'(QUEUE_DEPTH))
                       ? QA'(tail_sum - (FW+1)'(QUEUE_DEPTH)) : QA'(tail_sum);
    assign head_dec  = (head_reg == '0) ? QA'(QUEUE_DEPTH - 1) : head_reg - QA'(1);
    assign head_inc  = (head_reg == QA'(QUEUE_DEPTH - 1)) ? '0 : head_reg + QA'(1);

    // lowest free timed slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TIMED_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    // request checks
    assign push_ok      = (5'(cmd.solenoid) < 5'(NUM_MOMENTARY))
                          && (cmd.override_enable || enabled_reg);
    assign front_ok     = enabled_reg;
    assign due          = used_reg[scan_idx_reg] && (slot_rd_data_reg.when < time_reg);
    assign scan_push_ok = (5'(slot_rd_data_reg.sol) < 5'(NUM_MOMENTARY))
                          && (slot_rd_data_reg.ovr || enabled_reg);
    assign scan_last    = (scan_idx_reg == SW'(TIMED_SLOTS - 1));

    // tick: count the restore timer down and set the held bits again when it runs out
    always_comb
    begin
        tick_cd   = countdown_reg;
        tick_mask = restore_mask_reg;
        tick_port = port_reg;
        if (countdown_reg != 8'd0)
        begin
            tick_cd = countdown_reg - 8'd1;
            if (tick_cd == 8'd0)
            begin
                tick_port = port_reg | restore_mask_reg;
                tick_mask = 8'd0;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfs_pkg::ST_INIT:
                state_next = sfs_pkg::ST_IDLE;
            sfs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        sfs_pkg::OP_PUSH_BACK:
                            if (push_ok) state_next = sfs_pkg::ST_PUSH_BACK;
                        sfs_pkg::OP_PUSH_FRONT:
                            if (front_ok) state_next = sfs_pkg::ST_PUSH_FRONT;
                        sfs_pkg::OP_TIME:
                            state_next = sfs_pkg::ST_SCAN_RD;
                        sfs_pkg::OP_TICK:
                            if (fill_reg != '0) state_next = sfs_pkg::ST_TICK;
                        default:
                            state_next = sfs_pkg::ST_IDLE;
                    endcase
                end
            end
            sfs_pkg::ST_PUSH_BACK:
            begin
                if (rep_done)
                begin
                    if (!in_scan_reg || scan_last) state_next = sfs_pkg::ST_IDLE;
                    else                           state_next = sfs_pkg::ST_SCAN_RD;
                end
            end
            sfs_pkg::ST_PUSH_FRONT:
                if (rep_done) state_next = sfs_pkg::ST_IDLE;
            sfs_pkg::ST_SCAN_RD:
                state_next = sfs_pkg::ST_SCAN_CHK;
            sfs_pkg::ST_SCAN_CHK:
            begin
                if (due && scan_push_ok) state_next = sfs_pkg::ST_PUSH_BACK;
                else if (scan_last)      state_next = sfs_pkg::ST_IDLE;
                else                     state_next = sfs_pkg::ST_SCAN_RD;
            end
            sfs_pkg::ST_TICK:
                state_next = sfs_pkg::ST_IDLE;
            default:
                state_next = sfs_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        port_next         = port_reg;
        restore_mask_next = restore_mask_reg;
        countdown_next    = countdown_reg;
        enabled_next      = enabled_reg;
        head_next         = head_reg;
        fill_next         = fill_reg;
        used_next         = used_reg;
        time_next         = time_reg;
        rep_next          = rep_reg;
        psol_next         = psol_reg;
        in_scan_next      = in_scan_reg;
        scan_idx_next     = scan_idx_reg;
        emit              = 1'b0;
        written           = 1'b0;
        accepted          = 1'b0;
        q_wr_en           = 1'b0;
        q_wr_addr         = tail_addr;
        q_rd_en           = 1'b0;
        slot_wr_en        = 1'b0;
        slot_rd_en        = 1'b0;
        case (state_reg)
            sfs_pkg::ST_INIT:
                port_next = default_reg;
            sfs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        sfs_pkg::OP_PUSH_BACK:
                        begin
                            rep_next     = cmd.repeat_count;
                            psol_next    = cmd.solenoid;
                            in_scan_next = 1'b0;
                            emit         = !push_ok;
                        end
                        sfs_pkg::OP_PUSH_FRONT:
                        begin
                            rep_next  = cmd.repeat_count;
                            psol_next = cmd.solenoid;
                            emit      = !front_ok;
                        end
                        sfs_pkg::OP_SCHEDULE:
                        begin
                            if (free_found)
                            begin
                                used_next[free_idx] = 1'b1;
                                slot_wr_en          = 1'b1;
                                accepted            = 1'b1;
                            end
                            emit = 1'b1;
                        end
                        sfs_pkg::OP_TIME:
                        begin
                            time_next     = cmd.event_time;
                            scan_idx_next = '0;
                        end
                        sfs_pkg::OP_SET_BITS:
                        begin
                            if (cmd.level) port_next = port_reg | cmd.bit_mask;
                            else           port_next = port_reg & ~cmd.bit_mask;
                            written = 1'b1;
                            emit    = 1'b1;
                        end
                        sfs_pkg::OP_FIRE:
                        begin
                            if (countdown_reg == 8'd0)
                            begin
                                countdown_next    = cmd.hold_ticks;
                                restore_mask_next = cmd.bit_mask;
                                port_next         = port_reg & ~cmd.bit_mask;
                                written           = 1'b1;
                                accepted          = 1'b1;
                            end
                            emit = 1'b1;
                        end
                        sfs_pkg::OP_TICK:
                        begin
                            if (fill_reg == '0)
                            begin
                                countdown_next    = tick_cd;
                                restore_mask_next = tick_mask;
                                port_next = (tick_port & sfs_pkg::NIBBLE_HIGH)
                                            | {4'd0, sfs_pkg::NONE_CODE};
                                written   = 1'b1;
                                emit      = 1'b1;
                            end
                            else
                            begin
                                q_rd_en = 1'b1;
                            end
                        end
                        sfs_pkg::OP_ENABLE:
                        begin
                            enabled_next = 1'b1;
                            emit         = 1'b1;
                        end
                        sfs_pkg::OP_DISABLE:
                        begin
                            enabled_next = 1'b0;
                            emit         = 1'b1;
                        end
                        sfs_pkg::OP_CLEAR:
                        begin
                            head_next = '0;
                            fill_next = '0;
                            used_next = '0;
                            emit      = 1'b1;
                        end
                        default:
                            emit = 1'b1;
                    endcase
                end
            end
            sfs_pkg::ST_PUSH_BACK:
            begin
                if (rep_done)
                begin
                    if (!in_scan_reg || scan_last) emit = 1'b1;
                    else scan_idx_next = scan_idx_reg + SW'(1);
                end
                else
                begin
                    q_wr_en   = 1'b1;
                    q_wr_addr = tail_addr;
                    fill_next = fill_reg + FW'(1);
                    rep_next  = rep_reg - 8'd1;
                end
            end
            sfs_pkg::ST_PUSH_FRONT:
            begin
                if (rep_done)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    q_wr_en   = 1'b1;
                    q_wr_addr = head_dec;
                    head_next = head_dec;
                    fill_next = fill_reg + FW'(1);
                    rep_next  = rep_reg - 8'd1;
                end
            end
            sfs_pkg::ST_SCAN_RD:
                slot_rd_en = 1'b1;
            sfs_pkg::ST_SCAN_CHK:
            begin
                if (due)
                begin
                    used_next[scan_idx_reg] = 1'b0;
                end
                if (due && scan_push_ok)
                begin
                    rep_next     = slot_rd_data_reg.reps;
                    psol_next    = slot_rd_data_reg.sol;
                    in_scan_next = 1'b1;
                end
                else if (scan_last)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + SW'(1);
                end
            end
            sfs_pkg::ST_TICK:
            begin
                countdown_next    = tick_cd;
                restore_mask_next = tick_mask;
                port_next = (tick_port & sfs_pkg::NIBBLE_HIGH) | {4'd0, q_rd_data_reg};
                head_next = head_inc;
                fill_next = fill_reg - FW'(1);
                written   = 1'b1;
                emit      = 1'b1;
            end
            default:
                emit = 1'b0;
        endcase

        // result register
        out_valid_next       = out_valid_reg && !result.ready;
        out_next             = out_reg;
        if (emit)
        begin
            out_valid_next        = 1'b1;
            out_next.port_byte    = port_next;
            out_next.port_written = written;
            out_next.accepted     = accepted;
            out_next.queue_level  = 7'(fill_next);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sfs_pkg::ST_INIT;
            default_reg      <= sfs_pkg::PORT_RESET;
            port_reg         <= sfs_pkg::PORT_RESET;
            restore_mask_reg <= 8'd0;
            countdown_reg    <= 8'd0;
            enabled_reg      <= 1'b1;
            head_reg         <= '0;
            fill_reg         <= '0;
            used_reg         <= '0;
            in_scan_reg      <= 1'b0;
            scan_idx_reg     <= '0;
            rep_reg          <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_write)
            begin
                default_reg <= cfg_data;
            end
            port_reg         <= port_next;
            restore_mask_reg <= restore_mask_next;
            countdown_reg    <= countdown_next;
            enabled_reg      <= enabled_next;
            head_reg         <= head_next;
            fill_reg         <= fill_next;
            used_reg         <= used_next;
            in_scan_reg      <= in_scan_next;
            scan_idx_reg     <= scan_idx_next;
            rep_reg          <= rep_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        psol_reg <= psol_next;
        out_reg  <= out_next;
    end

    // fire queue memory
    always_ff @(posedge clk)
    begin
        if (q_wr_en)
        begin
            queue_mem[q_wr_addr] <= psol_reg;
        end
        if (q_rd_en)
        begin
            q_rd_data_reg <= queue_mem[head_reg];
        end
    end

    // timed slot memory
    always_ff @(posedge clk)
    begin
        if (slot_wr_en)
        begin
            slot_mem[free_idx] <= '{when: cmd.event_time, ovr: cmd.override_enable,
                                    sol: cmd.solenoid, reps: cmd.repeat_count};
        end
        if (slot_rd_en)
        begin
            slot_rd_data_reg <= slot_mem[scan_idx_reg];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.port_byte    = out_reg.port_byte;
    assign result.port_written = out_reg.port_written;
    assign result.accepted     = out_reg.accepted;
    assign result.queue_level  = out_reg.queue_level;

    // queue count never passes the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("fire queue count above depth");

    // a request is taken only in idle
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> state_reg == sfs_pkg::ST_IDLE)
        else $error("request taken while busy");

    // while busy no earlier result is still waiting
    a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sfs_pkg::ST_IDLE && state_reg != sfs_pkg::ST_INIT) |-> !out_valid_reg)
        else $error("busy with a result still pending");

    // scan index stays inside the slot table
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= SW'(TIMED_SLOTS - 1))
        else $error("slot scan index out of range");

endmodule
